@@ design/ppr_pkg.sv @@
// ----------------------------------------------------------------------------
// ppr_pkg: shared types, constants and microcode for the PID pump regulator
// Widths, register indexes, datapath op codes, branch codes and the control
// store read by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

  // field and datapath widths
  localparam int DATA_W    = 16;  // input, config and output values
  localparam int ERR_W     = 17;  // setpoint - actual
  localparam int DIFF_W    = 18;  // error change
  localparam int INTEG_W   = 32;  // integrator
  localparam int HOLD_W    = 8;   // hold-off counter
  localparam int MUL_A_W   = 17;  // unsigned gain or scale, as signed
  localparam int MUL_B_W   = 33;  // signed operand
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_W     = 48;  // dividend magnitude
  localparam int Q_W       = 34;  // signed quotient
  localparam int ACC_W     = 40;  // drive accumulator
  localparam int DIV_BITS  = 4;   // quotient bits per cycle
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int K_SCALE   = 1000;

  // config register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX    = 3'd6;

  // item op codes
  localparam logic OP_IN_RESTART = 1'b0;
  localparam logic OP_IN_STEP    = 1'b1;

  // datapath op codes (one per control word)
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP          = 5'd0;
  localparam logic [OP_W-1:0] OP_MUL_OFFS     = 5'd1;   // prod = -offset * 1000
  localparam logic [OP_W-1:0] OP_MUL_MAX      = 5'd2;   // prod = max * 1000
  localparam logic [OP_W-1:0] OP_MUL_P        = 5'd3;   // prod = gain_p * e
  localparam logic [OP_W-1:0] OP_MUL_I        = 5'd4;   // prod = gain_i * integ
  localparam logic [OP_W-1:0] OP_MUL_D        = 5'd5;   // prod = gain_d * (e - prev)
  localparam logic [OP_W-1:0] OP_DIV_GI       = 5'd6;   // q = prod / gain_i
  localparam logic [OP_W-1:0] OP_DIV_NORM     = 5'd7;   // q = prod / normalizer
  localparam logic [OP_W-1:0] OP_DIV_K        = 5'd8;   // q = prod / 1000
  localparam logic [OP_W-1:0] OP_RESTART      = 5'd9;
  localparam logic [OP_W-1:0] OP_INTEG_ADD    = 5'd10;
  localparam logic [OP_W-1:0] OP_INTEG_CLAMP  = 5'd11;
  localparam logic [OP_W-1:0] OP_SET_INTEG    = 5'd12;
  localparam logic [OP_W-1:0] OP_HOLD_DEC     = 5'd13;
  localparam logic [OP_W-1:0] OP_ACC_OFFS     = 5'd14;
  localparam logic [OP_W-1:0] OP_ACC_ADD_Q    = 5'd15;
  localparam logic [OP_W-1:0] OP_ACC_ADD_PROD = 5'd16;
  localparam logic [OP_W-1:0] OP_EMIT         = 5'd17;

  // sequencer branch codes
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
  localparam logic [COND_W-1:0] C_JUMP     = 3'd1;
  localparam logic [COND_W-1:0] C_GI_ZERO  = 3'd2;  // jump when gain_i == 0
  localparam logic [COND_W-1:0] C_HOLD_NZ  = 3'd3;  // jump while hold-off runs
  localparam logic [COND_W-1:0] C_RESTART  = 3'd4;  // jump on restart item
  localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd5;  // stall while divider runs
  localparam logic [COND_W-1:0] C_OUT_FULL = 3'd6;  // stall while output held
  localparam logic [COND_W-1:0] C_DONE     = 3'd7;  // end of program

  // program addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_ENTRY   = 5'd0;
  localparam logic [PC_W-1:0] PC_HOLD    = 5'd8;
  localparam logic [PC_W-1:0] PC_TERMS   = 5'd9;
  localparam logic [PC_W-1:0] PC_DONE    = 5'd21;
  localparam logic [PC_W-1:0] PC_RESTART = 5'd22;

  typedef struct packed {
    logic [DATA_W-1:0]        gain_p;
    logic [DATA_W-1:0]        gain_i;
    logic [DATA_W-1:0]        gain_d;
    logic [DATA_W-1:0]        normalizer;
    logic signed [DATA_W-1:0] drive_offset;
    logic signed [DATA_W-1:0] drive_min;
    logic signed [DATA_W-1:0] drive_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:       16'h0000,
    gain_i:       16'h0000,
    gain_d:       16'h0000,
    normalizer:   16'h0001,
    drive_offset: 16'sh0000,
    drive_min:    16'sh8000,
    drive_max:    16'sh7FFF
  };

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_word_t;

  typedef struct packed {
    logic            fire;
    logic [OP_W-1:0] op;
  } dp_ctrl_t;

  typedef struct packed {
    logic gi_zero;
    logic hold_nz;
    logic restart;
    logic div_busy;
    logic out_full;
  } dp_status_t;

  // control store
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: C_DONE, target: PC_ENTRY};
    case (addr)
      // regulate tick: integrator update
      5'd0:  w = '{op: OP_NOP,          cond: C_RESTART,  target: PC_RESTART};
      5'd1:  w = '{op: OP_NOP,          cond: C_GI_ZERO,  target: PC_TERMS};
      5'd2:  w = '{op: OP_NOP,          cond: C_HOLD_NZ,  target: PC_HOLD};
      5'd3:  w = '{op: OP_MUL_MAX,      cond: C_NEXT,     target: PC_ENTRY};
      5'd4:  w = '{op: OP_DIV_GI,       cond: C_NEXT,     target: PC_ENTRY};
      5'd5:  w = '{op: OP_INTEG_ADD,    cond: C_NEXT,     target: PC_ENTRY};
      5'd6:  w = '{op: OP_NOP,          cond: C_DIV_BUSY, target: PC_ENTRY};
      5'd7:  w = '{op: OP_INTEG_CLAMP,  cond: C_JUMP,     target: PC_TERMS};
      5'd8:  w = '{op: OP_HOLD_DEC,     cond: C_NEXT,     target: PC_ENTRY};
      // regulate tick: output terms
      5'd9:  w = '{op: OP_MUL_P,        cond: C_NEXT,     target: PC_ENTRY};
      5'd10: w = '{op: OP_DIV_NORM,     cond: C_NEXT,     target: PC_ENTRY};
      5'd11: w = '{op: OP_ACC_OFFS,     cond: C_NEXT,     target: PC_ENTRY};
      5'd12: w = '{op: OP_MUL_I,        cond: C_NEXT,     target: PC_ENTRY};
      5'd13: w = '{op: OP_NOP,          cond: C_DIV_BUSY, target: PC_ENTRY};
      5'd14: w = '{op: OP_ACC_ADD_Q,    cond: C_NEXT,     target: PC_ENTRY};
      5'd15: w = '{op: OP_DIV_K,        cond: C_NEXT,     target: PC_ENTRY};
      5'd16: w = '{op: OP_MUL_D,        cond: C_NEXT,     target: PC_ENTRY};
      5'd17: w = '{op: OP_NOP,          cond: C_DIV_BUSY, target: PC_ENTRY};
      5'd18: w = '{op: OP_ACC_ADD_Q,    cond: C_NEXT,     target: PC_ENTRY};
      5'd19: w = '{op: OP_ACC_ADD_PROD, cond: C_NEXT,     target: PC_ENTRY};
      5'd20: w = '{op: OP_EMIT,         cond: C_OUT_FULL, target: PC_ENTRY};
      5'd21: w = '{op: OP_NOP,          cond: C_DONE,     target: PC_ENTRY};
      // restart
      5'd22: w = '{op: OP_RESTART,      cond: C_GI_ZERO,  target: PC_DONE};
      5'd23: w = '{op: OP_MUL_OFFS,     cond: C_NEXT,     target: PC_ENTRY};
      5'd24: w = '{op: OP_DIV_GI,       cond: C_NEXT,     target: PC_ENTRY};
      5'd25: w = '{op: OP_NOP,          cond: C_DIV_BUSY, target: PC_ENTRY};
      5'd26: w = '{op: OP_SET_INTEG,    cond: C_JUMP,     target: PC_DONE};
      default: w = '{op: OP_NOP,        cond: C_DONE,     target: PC_ENTRY};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/ppr_div.sv @@
// ----------------------------------------------------------------------------
// ppr_div: shared iterative divider
// Signed dividend by positive 16-bit divisor, truncating toward zero.
// Restoring, DIV_BITS quotient bits per cycle, then a final sign-fix step.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_div import ppr_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [PROD_W-1:0] dividend,
  input  wire logic [DATA_W-1:0]        divisor,
  output logic                          busy,
  output logic signed [Q_W-1:0]         quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     num;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dsr;
  logic                 neg;

  logic [PROD_W-1:0]    mag;
  logic [DIV_W-1:0]     num_next;
  logic [DATA_W-1:0]    rem_next;
  logic [DATA_W:0]      trial;

  assign mag = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);

  // DIV_BITS restoring steps on a 17-bit partial remainder
  always_comb begin
    num_next = num;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial    = {rem_next, num_next[DIV_W-1]};
      num_next = {num_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial       = trial - {1'b0, dsr};
        num_next[0] = 1'b1;
      end
      rem_next = trial[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= mag[DIV_W-1:0];
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[PROD_W-1];
    end else if (busy) begin
      if (cnt != '0) begin
        num <= num_next;
        rem <= rem_next;
      end else begin
        quotient <= neg ? -$signed(num[Q_W-1:0]) : $signed(num[Q_W-1:0]);
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");

endmodule

`default_nettype wire

@@ design/ppr_dp.sv @@
// ----------------------------------------------------------------------------
// ppr_dp: regulator datapath
// Item and state registers, multiplier, accumulator, clamps and the output
// register, driven one op per cycle by the sequencer while it is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_dp import ppr_pkg::*; #(
  parameter logic [HOLD_W-1:0] HOLDOFF = 8'd200
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cfg_t                     cfg,
  input  wire logic                     start,
  input  wire logic                     in_op,
  input  wire logic signed [DATA_W-1:0] in_actual,
  input  wire logic                     in_actual_valid,
  input  wire logic signed [DATA_W-1:0] in_setpoint,
  input  wire dp_ctrl_t                 ctrl,
  output dp_status_t                    status,
  output logic                          m_valid,
  input  wire logic                     m_ready,
  output logic signed [DATA_W-1:0]      m_drive,
  output logic                          m_held
);

  // state
  logic signed [INTEG_W-1:0] integ;
  logic signed [ERR_W-1:0]   prev_e;
  logic                      prev_valid;
  logic [HOLD_W-1:0]         holdoff;
  logic                      held;

  // per-item working registers
  logic                      is_restart;
  logic signed [ERR_W-1:0]   e;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [ERR_W-1:0]   e_new;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_out;
  logic                      div_start;
  logic [DATA_W-1:0]         div_dsr;
  logic                      div_busy;
  logic signed [Q_W-1:0]     q;
  logic signed [Q_W-1:0]     ix;
  logic signed [Q_W-1:0]     nlim;
  logic signed [Q_W-1:0]     ic1;
  logic signed [Q_W-1:0]     ic2;
  logic signed [ACC_W-1:0]   lo;
  logic signed [ACC_W-1:0]   hi;
  logic signed [ACC_W-1:0]   v1;
  logic signed [ACC_W-1:0]   v2;
  logic                      fire_op;

  // invalid reading counts as zero error
  assign e_new = in_actual_valid ?
                 ERR_W'({in_setpoint[DATA_W-1], in_setpoint} - {in_actual[DATA_W-1], in_actual}) :
                 '0;
  assign diff  = {e[ERR_W-1], e} - {prev_e[ERR_W-1], prev_e};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_MUL_OFFS: begin
        mul_a = MUL_A_W'(K_SCALE);
        mul_b = -{{(MUL_B_W-DATA_W){cfg.drive_offset[DATA_W-1]}}, cfg.drive_offset};
      end
      OP_MUL_MAX: begin
        mul_a = MUL_A_W'(K_SCALE);
        mul_b = {{(MUL_B_W-DATA_W){cfg.drive_max[DATA_W-1]}}, cfg.drive_max};
      end
      OP_MUL_P: begin
        mul_a = {1'b0, cfg.gain_p};
        mul_b = {{(MUL_B_W-ERR_W){e[ERR_W-1]}}, e};
      end
      OP_MUL_I: begin
        mul_a = {1'b0, cfg.gain_i};
        mul_b = {{(MUL_B_W-INTEG_W){integ[INTEG_W-1]}}, integ};
      end
      OP_MUL_D: begin
        mul_a = {1'b0, cfg.gain_d};
        mul_b = {{(MUL_B_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_dsr   = cfg.gain_i;
    case (ctrl.op)
      OP_DIV_GI: begin
        div_start = ctrl.fire;
        div_dsr   = cfg.gain_i;
      end
      OP_DIV_NORM: begin
        div_start = ctrl.fire;
        div_dsr   = (cfg.normalizer == '0) ? DATA_W'(1) : cfg.normalizer;
      end
      OP_DIV_K: begin
        div_start = ctrl.fire;
        div_dsr   = DATA_W'(K_SCALE);
      end
      default: begin
        div_start = 1'b0;
        div_dsr   = cfg.gain_i;
      end
    endcase
  end

  ppr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (q)
  );

  // integrator clamp: upper limit first, then the mirrored lower limit
  assign ix   = {{(Q_W-INTEG_W){integ[INTEG_W-1]}}, integ};
  assign nlim = -q;
  assign ic1  = (ix > q) ? q : ix;
  assign ic2  = (ic1 < nlim) ? nlim : ic1;

  // drive clamp: max applied last
  assign lo = {{(ACC_W-DATA_W){cfg.drive_min[DATA_W-1]}}, cfg.drive_min};
  assign hi = {{(ACC_W-DATA_W){cfg.drive_max[DATA_W-1]}}, cfg.drive_max};
  assign v1 = (acc < lo) ? lo : acc;
  assign v2 = (v1 > hi) ? hi : v1;

  assign fire_op = ctrl.fire;

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      integ      <= '0;
      prev_e     <= '0;
      prev_valid <= 1'b0;
      holdoff    <= HOLDOFF;
      held       <= 1'b0;
    end else begin
      // a new result replaces one leaving in the same cycle
      if (fire_op && ctrl.op == OP_EMIT) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      if (start) begin
        held <= 1'b0;
        if (in_op == OP_IN_STEP && !prev_valid) begin
          prev_e <= e_new;
        end
      end
      if (fire_op) begin
        case (ctrl.op)
          OP_RESTART: begin
            holdoff    <= HOLDOFF;
            prev_valid <= 1'b0;
          end
          OP_INTEG_ADD: begin
            integ <= integ + {{(INTEG_W-ERR_W){e[ERR_W-1]}}, e};
          end
          OP_INTEG_CLAMP: begin
            integ <= ic2[INTEG_W-1:0];
          end
          OP_SET_INTEG: begin
            integ <= q[INTEG_W-1:0];
          end
          OP_HOLD_DEC: begin
            holdoff <= holdoff - 1'b1;
            held    <= 1'b1;
          end
          OP_EMIT: begin
            prev_e     <= e;
            prev_valid <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      is_restart <= (in_op == OP_IN_RESTART);
      e          <= e_new;
    end
    if (fire_op) begin
      case (ctrl.op)
        OP_MUL_OFFS, OP_MUL_MAX, OP_MUL_P, OP_MUL_I, OP_MUL_D: begin
          prod <= mul_out;
        end
        OP_ACC_OFFS: begin
          acc <= {{(ACC_W-DATA_W){cfg.drive_offset[DATA_W-1]}}, cfg.drive_offset};
        end
        OP_ACC_ADD_Q: begin
          acc <= acc + {{(ACC_W-Q_W){q[Q_W-1]}}, q};
        end
        OP_ACC_ADD_PROD: begin
          acc <= acc + prod[ACC_W-1:0];
        end
        OP_EMIT: begin
          m_drive <= v2[DATA_W-1:0];
          m_held  <= held;
        end
        default: ;
      endcase
    end
  end

  assign status.gi_zero  = (cfg.gain_i == '0);
  assign status.hold_nz  = (holdoff != '0);
  assign status.restart  = is_restart;
  assign status.div_busy = div_busy;
  assign status.out_full = m_valid && !m_ready;

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (ctrl.fire && ctrl.op == OP_EMIT) |=> m_valid)
    else $error("emitted result not presented");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_holdoff_steady: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.fire && (ctrl.op == OP_RESTART || ctrl.op == OP_HOLD_DEC))
    |=> holdoff == $past(holdoff))
    else $error("hold-off count changed without restart or decrement");

endmodule

`default_nettype wire

@@ design/ppr_seq.sv @@
// ----------------------------------------------------------------------------
// ppr_seq: microcode sequencer
// Step counter over the control store, branch and stall handling, busy flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_seq import ppr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output dp_ctrl_t        ctrl,
  output logic            active
);

  logic [PC_W-1:0] pc;
  ctrl_word_t      cw;
  logic            taken;
  logic            stall;

  assign cw = ucode_rom(pc);

  always_comb begin
    taken = 1'b0;
    case (cw.cond)
      C_NEXT:     taken = 1'b0;
      C_JUMP:     taken = 1'b1;
      C_GI_ZERO:  taken = status.gi_zero;
      C_HOLD_NZ:  taken = status.hold_nz;
      C_RESTART:  taken = status.restart;
      default:    taken = 1'b0;
    endcase
  end

  assign stall = (cw.cond == C_DIV_BUSY && status.div_busy) ||
                 (cw.cond == C_OUT_FULL && status.out_full);

  assign ctrl.fire = active && !stall;
  assign ctrl.op   = cw.op;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pc     <= PC_ENTRY;
    end else if (start) begin
      active <= 1'b1;
      pc     <= PC_ENTRY;
    end else if (active && !stall) begin
      if (cw.cond == C_DONE) begin
        active <= 1'b0;
      end else if (taken) begin
        pc <= cw.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/pid_pump_regulator_unit.sv @@
// ----------------------------------------------------------------------------
// pid_pump_regulator_unit: PID pump regulator with integrator clamp
// Items: one at a time. A regulate item gives one result, held back while an
//   older result still waits in the output register; a restart item gives none.
//   The time per item is set by the shared divider, used up to three times per
//   regulate item and at most once per restart.
// Reset (rst, synchronous): config to defaults, integrator and previous
//   error cleared, hold-off reloaded, sequencer idle, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_pump_regulator_unit import ppr_pkg::*; #(
  parameter int unsigned HOLDOFF_TICKS = 200
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input items
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [39:0]          s_tdata,   // actual[15:0], actual_valid, setpoint[15:0], pad
  input  wire logic [0:0]           s_tuser,   // op: 0 restart, 1 regulate
  // result items
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [DATA_W-1:0]         m_tdata,   // drive[15:0]
  output logic [0:0]                m_tuser,   // holdoff_active
  // config writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  cfg_t                     cfg;
  logic                     start;
  logic                     active;
  dp_ctrl_t                 ctrl;
  dp_status_t               status;
  logic signed [DATA_W-1:0] drive;
  logic                     held;

  // Config registers; the host must write them only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:       cfg.gain_p       <= cfg_data;
        REG_GAIN_I:       cfg.gain_i       <= cfg_data;
        REG_GAIN_D:       cfg.gain_d       <= cfg_data;
        REG_NORMALIZER:   cfg.normalizer   <= cfg_data;
        REG_DRIVE_OFFSET: cfg.drive_offset <= $signed(cfg_data);
        REG_DRIVE_MIN:    cfg.drive_min    <= $signed(cfg_data);
        REG_DRIVE_MAX:    cfg.drive_max    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // An item is taken whenever the sequencer is idle and out of reset. A
  // waiting result sits in the output register, so the next item may start;
  // a regulate item stalls only at its emit step until the old result is gone.
  assign s_tready = !active && !rst;
  assign start    = s_tvalid && s_tready;

  ppr_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .active (active)
  );

  // Datapath: one multiplier, one shared divider, accumulator and clamps.
  ppr_dp #(
    .HOLDOFF (HOLD_W'(HOLDOFF_TICKS))
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .start           (start),
    .in_op           (s_tuser[0]),
    .in_actual       ($signed(s_tdata[15:0])),
    .in_actual_valid (s_tdata[16]),
    .in_setpoint     ($signed(s_tdata[32:17])),
    .ctrl            (ctrl),
    .status          (status),
    .m_valid         (m_tvalid),
    .m_ready         (m_tready),
    .m_drive         (drive),
    .m_held          (held)
  );

  assign m_tdata    = drive;
  assign m_tuser[0] = held;

endmodule

`default_nettype wire

@@ tb/sv/ppr_drive_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppr_drive_checker: drive prediction and compare for the PID pump regulator
// Watches the config port and both item channels, keeps its own copy of the
// regulator state, and compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------

module ppr_drive_checker import ppr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [39:0]          s_tdata,   // actual[15:0], actual_valid, setpoint[15:0], pad
  input  logic [0:0]           s_tuser,   // op
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [DATA_W-1:0]    m_tdata,   // drive[15:0]
  input  logic [0:0]           m_tuser,   // holdoff_active
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending_cnt
);

  localparam int     HOLDOFF_RELOAD = 200;
  localparam longint K = K_SCALE;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     held;
  } drive_result_t;

  drive_result_t drive_expect_q[$];

  cfg_t   shadow_cfg;
  longint integ;
  longint prev_err;
  logic   prev_ok;
  int     hold_left;

  // one input item through the regulator; a regulate tick queues its drive
  task automatic predict_tick(input logic op, input logic signed [15:0] act,
                              input logic act_ok, input logic signed [15:0] sp);
    longint gp, gi, gd, gn, offs, lo, hi, e, lim, acc;
    drive_result_t r;
    gp   = longint'(shadow_cfg.gain_p);
    gi   = longint'(shadow_cfg.gain_i);
    gd   = longint'(shadow_cfg.gain_d);
    gn   = longint'(shadow_cfg.normalizer);
    offs = longint'($signed(shadow_cfg.drive_offset));
    lo   = longint'($signed(shadow_cfg.drive_min));
    hi   = longint'($signed(shadow_cfg.drive_max));
    if (op == OP_IN_RESTART) begin
      hold_left = HOLDOFF_RELOAD;
      if (gi != 0) integ = (-offs * K) / gi;
      prev_ok = 1'b0;
      return;
    end
    e = act_ok ? (longint'(sp) - longint'(act)) : 64'sd0;
    if (!prev_ok) begin
      prev_err = e;
      prev_ok  = 1'b1;
    end
    r.held = 1'b0;
    if (gi != 0) begin
      if (hold_left > 0) begin
        hold_left--;
        r.held = 1'b1;
      end else begin
        // limit may be negative; the second compare then wins
        lim   = (hi * K) / gi;
        integ = integ + e;
        if (integ > lim) integ = lim;
        if (integ < -lim) integ = -lim;
      end
    end
    if (gn == 0) gn = 1;
    acc = (gp * e) / gn + (gi * integ) / K + gd * (e - prev_err) + offs;
    if (acc < lo) acc = lo;
    if (acc > hi) acc = hi;
    prev_err = e;
    r.drive  = acc[15:0];
    drive_expect_q.push_back(r);
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      shadow_cfg = CFG_RESET;
      integ      = 0;
      prev_err   = 0;
      prev_ok    = 1'b0;
      hold_left  = HOLDOFF_RELOAD;
      drive_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:       shadow_cfg.gain_p       = cfg_data;
          REG_GAIN_I:       shadow_cfg.gain_i       = cfg_data;
          REG_GAIN_D:       shadow_cfg.gain_d       = cfg_data;
          REG_NORMALIZER:   shadow_cfg.normalizer   = cfg_data;
          REG_DRIVE_OFFSET: shadow_cfg.drive_offset = cfg_data;
          REG_DRIVE_MIN:    shadow_cfg.drive_min    = cfg_data;
          REG_DRIVE_MAX:    shadow_cfg.drive_max    = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_tick(s_tuser[0], s_tdata[15:0], s_tdata[16], s_tdata[32:17]);
      if (m_tvalid && m_tready) begin
        if (drive_expect_q.size() == 0) begin
          $error("result item with no prediction waiting: drive %0d", $signed(m_tdata));
          fail_count++;
        end else begin
          want = drive_expect_q.pop_front();
          if (m_tdata !== want.drive) begin
            $error("drive mismatch: expected %0d, actual %0d", want.drive, $signed(m_tdata));
            fail_count++;
          end
          if (m_tuser[0] !== want.held) begin
            $error("holdoff_active mismatch: expected %0d, actual %0d", want.held, m_tuser[0]);
            fail_count++;
          end
        end
      end
    end
    pending_cnt = drive_expect_q.size();
  end

endmodule

@@ tb/sv/tb_pid_pump_regulator_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_pump_regulator_unit: stimulus and verdict for the PID pump regulator
// Directed ticks at the field and register extremes, then phases of random
// regulate runs under changing settings, with random idling on both channels.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------

module tb_pid_pump_regulator_unit import ppr_pkg::*; ();

  localparam int SETTLE_CYCLES    = 100;  // worst regulate latency plus a restart
  localparam int SINK_HOLD_CYCLES = 400;  // long enough to back up the input side

  typedef enum {
    SET_MODERATE,
    SET_NEG_MAX,
    SET_NO_INTEG,
    SET_FULL_SCALE,
    SET_CROSSED,
    SET_ANY
  } set_kind_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata   = '0;  // actual[15:0], actual_valid, setpoint[15:0], pad
  logic [0:0]           s_tuser   = '0;  // op: 0 restart, 1 regulate
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [DATA_W-1:0]    m_tdata;         // drive[15:0]
  logic [0:0]           m_tuser;         // holdoff_active
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  int   fail_count;
  int   pending_cnt;

  // idling controls, written by the stimulus with nonblocking assignments
  logic no_idle    = 1'b0;
  int   stall_reqs = 0;

  always #4 clk = ~clk;

  pid_pump_regulator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppr_drive_checker u_drive_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt)
  );

  // mostly back-to-back or short gaps, a few that outlast a whole tick
  function automatic int pick_sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 40);
    return $urandom_range(60, 150);
  endfunction

  function automatic cfg_t make_settings(input logic [15:0] gp, input logic [15:0] gi,
                                         input logic [15:0] gd, input logic [15:0] nrm,
                                         input logic [15:0] offs, input logic [15:0] lo,
                                         input logic [15:0] hi);
    cfg_t s;
    s.gain_p       = gp;
    s.gain_i       = gi;
    s.gain_d       = gd;
    s.normalizer   = nrm;
    s.drive_offset = offs;
    s.drive_min    = lo;
    s.drive_max    = hi;
    return s;
  endfunction

  function automatic cfg_t rand_settings(input set_kind_t kind);
    logic [15:0] gp, gi, gd, nrm, offs, lo, hi;
    // moderate loop: gains small enough that the integrator matters
    gp   = 16'($urandom_range(0, 4000));
    gi   = 16'($urandom_range(1, 3000));
    gd   = 16'($urandom_range(0, 40));
    nrm  = 16'($urandom_range(1, 2000));
    offs = 16'($urandom_range(0, 4000) - 2000);
    lo   = 16'(-int'($urandom_range(1000, 32768)));
    hi   = 16'($urandom_range(1000, 32767));
    case (kind)
      SET_NEG_MAX: begin
        // negative integrator limit, integrator pinned at its mirror
        hi = 16'(-int'($urandom_range(1, 3000)));
        lo = 16'h8000;
      end
      SET_NO_INTEG: gi = 16'd0;
      SET_FULL_SCALE: begin
        gp  = 16'hFFFF;
        gi  = 16'hFFFF;
        gd  = 16'hFFFF;
        nrm = ($urandom_range(0, 1) != 0) ? 16'd1 : 16'hFFFF;
        lo  = 16'h8000;
        hi  = 16'h7FFF;
      end
      SET_CROSSED: begin
        // min above max: upper clamp wins
        lo = 16'($urandom_range(1000, 3000));
        hi = 16'($urandom_range(0, 999));
      end
      SET_ANY: begin
        gp   = 16'($urandom);
        gi   = 16'($urandom);
        gd   = 16'($urandom);
        nrm  = 16'($urandom);
        offs = 16'($urandom);
        lo   = 16'($urandom);
        hi   = 16'($urandom);
      end
      default: ;
    endcase
    return make_settings(gp, gi, gd, nrm, offs, lo, hi);
  endfunction

  // called right after a rising edge; returns at the edge that took the item,
  // with s_tvalid still high so the next item can follow without a bubble
  task automatic push_item(input logic op, input logic [15:0] act, input logic act_ok,
                           input logic [15:0] sp);
    int gap;
    gap = pick_sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, sp, act_ok, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic push_random_item(input int restart_pct);
    logic [15:0] sp, act, d;
    int pick;
    sp   = 16'($urandom);
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < restart_pct) begin
      // restart with junk payload
      push_item(OP_IN_RESTART, 16'($urandom), 1'($urandom), 16'($urandom));
    end else begin
      if (pick < 5) begin
        // near setpoint: keeps the loop out of saturation
        d   = 16'($urandom_range(0, 400));
        act = sp + d - 16'd200;
      end else if (pick < 8) begin
        act = 16'($urandom);
      end else begin
        act = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
        sp  = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      end
      push_item(OP_IN_STEP, act, $urandom_range(0, 11) != 0, sp);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // only while idle: every register, one write each
  task automatic apply_settings(input cfg_t s);
    write_reg(REG_GAIN_P,       s.gain_p);
    write_reg(REG_GAIN_I,       s.gain_i);
    write_reg(REG_GAIN_D,       s.gain_d);
    write_reg(REG_NORMALIZER,   s.normalizer);
    write_reg(REG_DRIVE_OFFSET, s.drive_offset);
    write_reg(REG_DRIVE_MIN,    s.drive_min);
    write_reg(REG_DRIVE_MAX,    s.drive_max);
    cfg_we <= 1'b0;
  endtask

  // stop offering, wait out every predicted result, then let a trailing
  // restart (which gives no result) finish; counts sampled at the falling edge
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_cnt != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int   len;
    int   stall_served;
    logic lvl;
    stall_served = 0;
    @(posedge clk);
    forever begin
      if (stall_served != stall_reqs) begin
        stall_served++;
        lvl = 1'b0;
        len = SINK_HOLD_CYCLES;
      end else if (no_idle) begin
        lvl = 1'b1;
        len = 1;
      end else if ($urandom_range(0, 99) < 65) begin
        lvl = 1'b1;
        len = $urandom_range(1, 24);
      end else begin
        lvl = 1'b0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
      end
      m_tready <= lvl;
      repeat (len) @(posedge clk);
    end
  end

  initial begin : stimulus
    set_kind_t kind;
    int        n_items;
    int        rpct;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: all gains zero, full-range clamp
    push_item(OP_IN_STEP, 16'h8000, 1'b1, 16'h7FFF);     // largest positive error
    push_item(OP_IN_STEP, 16'h7FFF, 1'b1, 16'h8000);     // largest negative error
    push_item(OP_IN_STEP, 16'h1234, 1'b0, 16'h0000);     // invalid measurement
    push_item(OP_IN_RESTART, 16'h0000, 1'b0, 16'h0000);  // integral gain zero: no preset
    settle();

    // every gain at full scale, normalizer zero, largest offset
    apply_settings(make_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                                 16'h7FFF, 16'h8000, 16'h7FFF));
    push_item(OP_IN_RESTART, 16'hFFFF, 1'b1, 16'hFFFF);
    push_item(OP_IN_STEP, 16'h8000, 1'b1, 16'h7FFF);     // previous error invalid
    push_item(OP_IN_STEP, 16'h7FFF, 1'b1, 16'h8000);     // full-swing derivative
    push_item(OP_IN_STEP, 16'h4000, 1'b0, 16'h0000);
    push_item(OP_IN_STEP, 16'h0000, 1'b1, 16'h0000);
    settle();

    // negative max with min above it, most negative offset
    apply_settings(make_settings(16'd1, 16'd1, 16'd0, 16'hFFFF,
                                 16'h8000, 16'h7FFF, 16'h8000));
    push_item(OP_IN_RESTART, 16'h0000, 1'b1, 16'h0000);
    push_item(OP_IN_STEP, 16'h0000, 1'b1, 16'd100);
    push_item(OP_IN_STEP, 16'd50, 1'b1, -16'sd100);
    push_item(OP_IN_STEP, 16'h7FFF, 1'b0, 16'h8000);
    settle();

    // integral gain zero: hold-off frozen, restart leaves integrator alone
    apply_settings(make_settings(16'd200, 16'd0, 16'd3, 16'd7,
                                 -16'sd50, -16'sd1000, 16'd1000));
    push_item(OP_IN_STEP, 16'd10, 1'b1, 16'd90);
    push_item(OP_IN_RESTART, 16'd0, 1'b0, 16'd0);
    push_item(OP_IN_STEP, 16'd90, 1'b1, 16'd10);
    push_item(OP_IN_STEP, 16'd30, 1'b1, 16'd30);

    // random phases; the first one runs the hold-off out so later phases
    // integrate, restarts only come back in the last three
    for (int phase = 0; phase < 9; phase++) begin
      n_items = 60;
      rpct    = 0;
      case (phase)
        0: begin kind = SET_MODERATE;   n_items = 230; end
        1:       kind = SET_NEG_MAX;
        2:       kind = SET_NO_INTEG;
        3:       kind = SET_FULL_SCALE;
        4:       kind = SET_CROSSED;
        5:       kind = SET_MODERATE;
        6: begin kind = SET_ANY;        rpct = 4; end
        7: begin kind = SET_MODERATE;   rpct = 4; end
        default: begin kind = SET_ANY;  rpct = 4; end
      endcase
      settle();
      apply_settings(rand_settings(kind));
      no_idle <= (phase == 3);
      if (phase == 1 || phase == 5) stall_reqs <= stall_reqs + 1;
      repeat (n_items) push_random_item(rpct);
    end

    settle();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // several times the slowest legal run
  initial begin : watchdog
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
